[rtl/dhcp_reply_parser_unit_macros.svh]
// ----------------------------------------------------------------------------
// DHCP reply parser assertion macros
// Shared concurrent-assertion shorthands, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef DHCP_REPLY_PARSER_UNIT_MACROS_SVH
`define DHCP_REPLY_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define DRP_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define DRP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/dhcprp_pkg.sv]
// ----------------------------------------------------------------------------
// DHCP reply parser package
// Fixed offsets, option codes, verdict codes and the classified beat type.
// ----------------------------------------------------------------------------
package dhcprp_pkg;

  // fixed payload layout
  localparam int OfferFieldLo  = 16;
  localparam int ServerFieldLo = 20;
  localparam int FieldBytes    = 4;
  localparam int OptionsStart  = 240;

  // option codes and values
  localparam logic [7:0] OPT_MSG_TYPE    = 8'd53;
  localparam logic [7:0] OPT_END         = 8'd255;
  localparam logic [7:0] OPT_SUBNET_MASK = 8'd1;
  localparam logic [7:0] OPT_GATEWAY     = 8'd3;
  localparam logic [7:0] OPT_BROADCAST   = 8'd28;
  localparam logic [7:0] MSG_OFFER       = 8'd2;
  localparam logic [7:0] MSG_ACK         = 8'd5;
  localparam logic [7:0] MASK_ALL_ONES   = 8'hff;

  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_OFFER = 2'd1,
    VERDICT_ACK   = 2'd2
  } verdict_t;

  // one payload byte plus what the front end learned from its offset
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       parse;         // offset below the payload limit
    logic       stage_offer;   // inside the your-address field
    logic       stage_server;  // inside the server-address field
    logic       at_type;       // first option position
  } beat_flags_t;

endpackage

[rtl/dhcprp_fifo.sv]
// ----------------------------------------------------------------------------
// DHCP reply parser beat queue
// Two-entry register queue between the front and back ends.
// ----------------------------------------------------------------------------
module dhcprp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty,
  output logic             full
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/dhcprp_front.sv]
// ----------------------------------------------------------------------------
// DHCP reply parser front end
// Accepts bytes, tracks the payload offset and classifies each beat.
// ----------------------------------------------------------------------------
module dhcprp_front #(
  parameter int MAX_PAYLOAD = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic                                 fifo_full,
  input  logic [7:0]                           data_byte,
  input  logic                                 end_of_packet,
  output logic                                 wr_en,
  output dhcprp_pkg::beat_flags_t              wr_flags,
  output logic [$clog2(MAX_PAYLOAD+1)-1:0]     wr_offset
);
  import dhcprp_pkg::*;

  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  logic [CW-1:0] offset;
  logic [CW-1:0] offset_next;
  logic          in_parse;

  assign wr_en    = push && !fifo_full;
  assign in_parse = (offset < CW'(MAX_PAYLOAD));

  always_comb begin
    wr_flags.data         = data_byte;
    wr_flags.last         = end_of_packet;
    wr_flags.parse        = in_parse;
    wr_flags.stage_offer  = (offset >= CW'(OfferFieldLo)) &&
                            (offset <  CW'(OfferFieldLo + FieldBytes));
    wr_flags.stage_server = (offset >= CW'(ServerFieldLo)) &&
                            (offset <  CW'(ServerFieldLo + FieldBytes));
    wr_flags.at_type      = (offset == CW'(OptionsStart));
  end

  assign wr_offset = offset;

  // offset saturates at the limit; last beat starts the next packet at zero
  always_comb begin
    offset_next = offset;
    if (wr_en) begin
      if (end_of_packet) begin
        offset_next = '0;
      end else if (in_parse) begin
        offset_next = offset + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else begin
      offset <= offset_next;
    end
  end

endmodule

[rtl/dhcprp_back.sv]
// ----------------------------------------------------------------------------
// DHCP reply parser back end
// Option walker, bound settings and the result register.
// ----------------------------------------------------------------------------
module dhcprp_back #(
  parameter int MAX_PAYLOAD = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              beat_valid,
  input  dhcprp_pkg::beat_flags_t           beat_flags,
  input  logic [$clog2(MAX_PAYLOAD+1)-1:0]  beat_offset,
  output logic                              beat_take,
  input  logic                              pop,
  output logic                              empty,
  output logic [1:0]                        verdict,
  output logic [31:0]                       offered_address,
  output logic [31:0]                       server_address,
  output logic [31:0]                       bound_address,
  output logic [31:0]                       gateway_address,
  output logic [2:0]                        mask_byte_count,
  output logic [31:0]                       broadcast_address
);
  import dhcprp_pkg::*;

  localparam int NW = $clog2(MAX_PAYLOAD + 256);

  typedef enum logic [5:0] {
    PH_HEADER   = 6'b000001,
    PH_TYPE_LEN = 6'b000010,
    PH_TYPE_VAL = 6'b000100,
    PH_OPT_CODE = 6'b001000,
    PH_OPT_LEN  = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_MASK,
    CAP_ROUTER,
    CAP_BCAST
  } cap_t;

  function automatic logic [2:0] ones_bytes(input logic [31:0] w);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (w[8*i +: 8] == MASK_ALL_ONES) begin
        n = n + 3'd1;
      end
    end
    return n;
  endfunction

  // per-packet state
  phase_t        phase, phase_next;
  verdict_t      kind, kind_next;
  cap_t          cap_code, cap_code_next;
  logic [2:0]    cap_count, cap_count_next;
  logic [31:0]   cap_word, cap_word_next;
  logic [31:0]   staged_offer, staged_offer_next;
  logic [31:0]   staged_server, staged_server_next;
  logic [NW-1:0] next_opt, next_opt_next;
  // bound settings
  logic [31:0]   own, own_next;
  logic [31:0]   router, router_next;
  logic [2:0]    mask_cnt, mask_cnt_next;
  logic [31:0]   bcast, bcast_next;
  // result register
  logic          out_valid, out_valid_next;
  verdict_t      out_verdict;

  logic [7:0]    b;
  logic [NW-1:0] off_ext;
  logic [NW-1:0] len_sum;
  logic [31:0]   word_shift;
  logic          do_code;
  logic          out_space;
  logic          out_load;

  assign out_space = !out_valid || pop;
  assign beat_take = beat_valid && (!beat_flags.last || out_space);
  assign out_load  = beat_take && beat_flags.last;

  assign b          = beat_flags.data;
  assign off_ext    = NW'(beat_offset);
  assign len_sum    = off_ext + NW'(1) + NW'(b);
  assign word_shift = {cap_word[23:0], b};

  always_comb begin
    phase_next         = phase;
    kind_next          = kind;
    cap_code_next      = cap_code;
    cap_count_next     = cap_count;
    cap_word_next      = cap_word;
    staged_offer_next  = staged_offer;
    staged_server_next = staged_server;
    next_opt_next      = next_opt;
    own_next           = own;
    router_next        = router;
    mask_cnt_next      = mask_cnt;
    bcast_next         = bcast;
    do_code            = 1'b0;

    if (beat_take && beat_flags.parse) begin
      // value capture runs in every phase once armed
      if (cap_count == 3'd1) begin
        cap_count_next = 3'd2;
      end else if (cap_count >= 3'd2) begin
        cap_word_next = word_shift;
        if (cap_count == 3'd5) begin
          case (cap_code)
            CAP_ROUTER: router_next   = word_shift;
            CAP_BCAST:  bcast_next    = word_shift;
            CAP_MASK:   mask_cnt_next = ones_bytes(word_shift);
            default:    ;
          endcase
          cap_count_next = 3'd0;
          cap_code_next  = CAP_NONE;
        end else begin
          cap_count_next = cap_count + 3'd1;
        end
      end

      if (beat_flags.stage_offer) begin
        staged_offer_next = {staged_offer[23:0], b};
      end
      if (beat_flags.stage_server) begin
        staged_server_next = {staged_server[23:0], b};
      end

      case (phase)
        PH_HEADER: begin
          if (beat_flags.at_type) begin
            phase_next = (b == OPT_MSG_TYPE) ? PH_TYPE_LEN : PH_DONE;
          end
        end
        PH_TYPE_LEN: begin
          next_opt_next = len_sum;
          phase_next    = PH_TYPE_VAL;
        end
        PH_TYPE_VAL: begin
          if (b == MSG_OFFER) begin
            kind_next  = VERDICT_OFFER;
            phase_next = PH_DONE;
          end else if (b == MSG_ACK) begin
            kind_next  = VERDICT_ACK;
            own_next   = staged_offer;
            phase_next = PH_OPT_CODE;
            do_code    = (off_ext == next_opt);
          end else begin
            kind_next  = VERDICT_NONE;
            phase_next = PH_DONE;
          end
        end
        PH_OPT_CODE: begin
          do_code = (off_ext == next_opt);
        end
        PH_OPT_LEN: begin
          next_opt_next = len_sum;
          phase_next    = PH_OPT_CODE;
        end
        default: ;
      endcase

      // option code byte: end, a captured option, or anything else
      if (do_code) begin
        if (b == OPT_END) begin
          phase_next = PH_DONE;
        end else begin
          case (b)
            OPT_SUBNET_MASK: begin
              cap_code_next  = CAP_MASK;
              cap_count_next = 3'd1;
              cap_word_next  = '0;
            end
            OPT_GATEWAY: begin
              cap_code_next  = CAP_ROUTER;
              cap_count_next = 3'd1;
              cap_word_next  = '0;
            end
            OPT_BROADCAST: begin
              cap_code_next  = CAP_BCAST;
              cap_count_next = 3'd1;
              cap_word_next  = '0;
            end
            default: ;
          endcase
          phase_next = PH_OPT_LEN;
        end
      end
    end

    // result reflects this beat; then the per-packet state starts over
    out_verdict = kind_next;
    if (out_load) begin
      phase_next         = PH_HEADER;
      kind_next          = VERDICT_NONE;
      cap_code_next      = CAP_NONE;
      cap_count_next     = 3'd0;
      cap_word_next      = '0;
      staged_offer_next  = '0;
      staged_server_next = '0;
      next_opt_next      = NW'(OptionsStart);
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (pop && out_valid) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      kind          <= VERDICT_NONE;
      cap_code      <= CAP_NONE;
      cap_count     <= 3'd0;
      cap_word      <= '0;
      staged_offer  <= '0;
      staged_server <= '0;
      next_opt      <= NW'(OptionsStart);
      own           <= '0;
      router        <= '0;
      mask_cnt      <= 3'd0;
      bcast         <= '0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      kind          <= kind_next;
      cap_code      <= cap_code_next;
      cap_count     <= cap_count_next;
      cap_word      <= cap_word_next;
      staged_offer  <= staged_offer_next;
      staged_server <= staged_server_next;
      next_opt      <= next_opt_next;
      own           <= own_next;
      router        <= router_next;
      mask_cnt      <= mask_cnt_next;
      bcast         <= bcast_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict           <= out_verdict;
      offered_address   <= (beat_flags.parse && beat_flags.stage_offer) ?
                           {staged_offer[23:0], b} : staged_offer;
      server_address    <= (beat_flags.parse && beat_flags.stage_server) ?
                           {staged_server[23:0], b} : staged_server;
      bound_address     <= own_next;
      gateway_address   <= router_next;
      mask_byte_count   <= mask_cnt_next;
      broadcast_address <= bcast_next;
    end
  end

  assign empty = !out_valid;

endmodule

[rtl/dhcp_reply_parser_unit.sv]
// ----------------------------------------------------------------------------
// DHCP reply parser unit
// Byte-serial parser for DHCP offer and ACK replies.
// ----------------------------------------------------------------------------
// Feed the UDP payload of a DHCP reply one byte per beat, starting at the op
// field, with end_of_packet high on the last byte. Each packet yields exactly
// one result beat, released after its last byte: the verdict (none, offer,
// ACK applied), the your-address and server-address fields of this packet,
// and the bound settings (own address, router, mask 0xff-byte count,
// broadcast) as they stand after the packet. Bound settings persist across
// packets until a later ACK overwrites them. The unit sustains one byte per
// clock while full stays low; the result passes through the beat queue
// and the result register, and waits while an earlier result awaits pop. Each
// byte costs the back end one option-offset add/compare and a few register
// updates, and a two-beat queue plus the result register let either side
// stall without stopping the other. Bytes at or beyond MAX_PAYLOAD are
// accepted but not parsed; their end mark still closes the packet.
// ----------------------------------------------------------------------------
module dhcp_reply_parser_unit #(
  parameter int MAX_PAYLOAD = 2048
) (
  input  logic        clk,
  input  logic        rst,
  // byte input queue
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        end_of_packet,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  verdict,
  output logic [31:0] offered_address,
  output logic [31:0] server_address,
  output logic [31:0] bound_address,
  output logic [31:0] gateway_address,
  output logic [2:0]  mask_byte_count,
  output logic [31:0] broadcast_address
);
  import dhcprp_pkg::*;

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int QW = $bits(beat_flags_t) + CW;

  // front end -> queue
  logic          wr_en;
  beat_flags_t   wr_flags;
  logic [CW-1:0] wr_offset;

  // queue -> back end
  logic [QW-1:0] rd_data;
  logic          q_not_empty;
  logic          q_full;
  logic          beat_take;
  beat_flags_t   rd_flags;
  logic [CW-1:0] rd_offset;

  assign full                  = q_full;
  assign {rd_flags, rd_offset} = rd_data;

  // offset tracking and per-byte classification
  dhcprp_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .fifo_full     (q_full),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .wr_en         (wr_en),
    .wr_flags      (wr_flags),
    .wr_offset     (wr_offset)
  );

  // two classified beats of slack between the halves
  dhcprp_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_data   ({wr_flags, wr_offset}),
    .rd_en     (beat_take),
    .rd_data   (rd_data),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // option walker, bound settings, result register
  dhcprp_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .beat_valid        (q_not_empty),
    .beat_flags        (rd_flags),
    .beat_offset       (rd_offset),
    .beat_take         (beat_take),
    .pop               (pop),
    .empty             (empty),
    .verdict           (verdict),
    .offered_address   (offered_address),
    .server_address    (server_address),
    .bound_address     (bound_address),
    .gateway_address   (gateway_address),
    .mask_byte_count   (mask_byte_count),
    .broadcast_address (broadcast_address)
  );

endmodule

[rtl/dhcprp_checker.sv]
// ----------------------------------------------------------------------------
// DHCP reply parser checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "dhcp_reply_parser_unit_macros.svh"

module dhcprp_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  verdict,
  input logic [31:0] offered_address,
  input logic [2:0]  mask_byte_count
);

  `DRP_ASSERT_IMPL(a_verdict_code, !empty, verdict != 2'd3, "verdict code out of range")
  `DRP_ASSERT_IMPL(a_mask_range, !empty, mask_byte_count <= 3'd4, "mask count above four")
  `DRP_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(verdict) && $stable(offered_address), "waiting result changed")
  `DRP_ASSERT_IMPL(a_reset_clean, $past(rst), empty && !full, "queues not clear after reset")

endmodule

bind dhcp_reply_parser_unit dhcprp_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .verdict         (verdict),
  .offered_address (offered_address),
  .mask_byte_count (mask_byte_count)
);
